/* rtl/core/kwm_pkg.sv */
// Shared types, codes and the entry ordering function of the k-way merge heap.
package kwm_pkg;

    localparam int VALUE_W = 32;
    localparam int LIST_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_RETIRE  = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
        logic [LIST_W-1:0]         list_id;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic [LIST_W-1:0]         top_list;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
        logic                      error;
    } t_out_item;

    // One heap slot: a list head and the list it belongs to.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [LIST_W-1:0]         list;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_ins;
        logic start_adv;
        logic start_ret;
        logic take_last;
        logic rd_up;
        logic rd_dn;
        logic up_move;
        logic dn_move;
        logic place;
        logic emit;
        logic err;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic zero;
        logic one;
        logic idx_zero;
        logic up_less;
        logic leaf;
        logic dn_swap;
    } t_status;

    // True when entry a belongs above entry b: smaller value, then lower list.
    function automatic logic entry_before(input t_entry a, input t_entry b);
        logic result;
        if (a.value != b.value) begin
            result = ($signed(a.value) < $signed(b.value));
        end else begin
            result = (a.list < b.list);
        end
        return result;
    endfunction

endpackage

/* rtl/core/kwm_dpath.sv */
// Datapath of the k-way merge heap: entry memory, hole register, index and count.
module kwm_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kwm_pkg::t_in_item  i_item,
    input  kwm_pkg::t_cmd      i_cmd,
    output kwm_pkg::t_status   o_status,
    output logic               o_valid,
    output kwm_pkg::t_out_item o_result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;

    kwm_pkg::t_entry r_mem [CAPACITY];
    kwm_pkg::t_entry r_rd_a;
    kwm_pkg::t_entry r_rd_b;
    kwm_pkg::t_entry r_cur;
    kwm_pkg::t_entry r_top;
    logic [IW-1:0]   r_idx;
    logic [CW-1:0]   r_count;
    logic            r_valid;
    kwm_pkg::t_out_item r_res;

    logic [IW-1:0]   idx_m1;
    logic [IW-1:0]   parent;
    logic [XW-1:0]   l_x;
    logic [XW-1:0]   r_x;
    logic [XW-1:0]   cnt_x;
    logic [CW-1:0]   cnt_dec;
    logic            l_ok;
    logic            r_ok;
    logic            win_a;
    logic            win_b;
    kwm_pkg::t_entry best_a;
    kwm_pkg::t_entry child_data;
    logic [IW-1:0]   child_idx;
    logic [IW-1:0]   addr_a;
    logic            wr_en;
    kwm_pkg::t_entry wr_data;
    logic [CW+kwm_pkg::COUNT_W-1:0] cnt_ext;

    assign idx_m1  = r_idx - 1'b1;
    assign parent  = idx_m1 >> 1;
    assign l_x     = {1'b0, r_idx, 1'b1};
    assign r_x     = {1'b0, r_idx, 1'b0} + XW'(2);
    assign cnt_x   = {{(XW-CW){1'b0}}, r_count};
    assign cnt_dec = r_count - 1'b1;
    assign l_ok    = (l_x < cnt_x);
    assign r_ok    = (r_x < cnt_x);

    // Pick the smallest of the hole entry and the two children.
    assign win_a      = l_ok && kwm_pkg::entry_before(r_rd_a, r_cur);
    assign best_a     = win_a ? r_rd_a : r_cur;
    assign win_b      = r_ok && kwm_pkg::entry_before(r_rd_b, best_a);
    assign child_data = win_b ? r_rd_b : r_rd_a;
    assign child_idx  = win_b ? r_x[IW-1:0] : l_x[IW-1:0];

    always_comb begin
        addr_a = l_x[IW-1:0];
        if (i_cmd.start_ret) begin
            addr_a = cnt_dec[IW-1:0];
        end else if (i_cmd.rd_up) begin
            addr_a = parent;
        end
    end

    always_comb begin
        wr_en   = i_cmd.place | i_cmd.up_move | i_cmd.dn_move;
        wr_data = r_cur;
        if (i_cmd.up_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.dn_move) begin
            wr_data = child_data;
        end
    end

    // Entry memory with two registered read ports and one write port.
    // The right child is only needed for a sift-down compare.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        if (i_cmd.rd_dn) begin
            r_rd_b <= r_mem[r_x[IW-1:0]];
        end
    end

    // Hole entry, index and root shadow.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_ins) begin
            r_cur.value <= i_item.value;
            r_cur.list  <= i_item.list_id;
            r_idx       <= r_count[IW-1:0];
        end else if (i_cmd.start_adv) begin
            r_cur.value <= i_item.value;
            r_cur.list  <= r_top.list;
            r_idx       <= '0;
        end else if (i_cmd.start_ret) begin
            r_idx <= '0;
        end else if (i_cmd.take_last) begin
            r_cur <= r_rd_a;
        end else if (i_cmd.up_move) begin
            r_idx <= parent;
        end else if (i_cmd.dn_move) begin
            r_idx <= child_idx;
        end
        if (wr_en && (r_idx == '0)) begin
            r_top <= wr_data;
        end
    end

    assign cnt_ext = {{kwm_pkg::COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.top_value <= (r_count == '0) ? '0 : r_top.value;
            r_res.top_list  <= (r_count == '0) ? '0 : r_top.list;
            r_res.count     <= cnt_ext[kwm_pkg::COUNT_W-1:0];
            r_res.empty_res <= (r_count == '0);
            r_res.error     <= i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.start_ins) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.start_ret) begin
                r_count <= cnt_dec;
            end
        end
    end

    assign o_status.full     = (r_count == CW'(CAPACITY));
    assign o_status.zero     = (r_count == '0);
    assign o_status.one      = (r_count == CW'(1));
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.up_less  = kwm_pkg::entry_before(r_cur, r_rd_a);
    assign o_status.leaf     = !l_ok;
    assign o_status.dn_swap  = win_a | win_b;

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count exceeds capacity");

    a_place_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place || i_cmd.up_move || i_cmd.dn_move) |-> ({1'b0, r_idx} < r_count))
        else $error("write to a slot outside the live heap");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.err) |=> $stable(r_count))
        else $error("refused operation changed the entry count");

endmodule

/* rtl/core/kwm_ctrl.sv */
// Controller state machine of the k-way merge heap: decodes items and sequences sifts.
module kwm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_kind,
    input  kwm_pkg::t_status i_status,
    output kwm_pkg::t_cmd    o_cmd,
    output logic             busy
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_CHK  = 7'b0000010,
        S_UP_CMP  = 7'b0000100,
        S_DN_LAST = 7'b0001000,
        S_DN_RD   = 7'b0010000,
        S_DN_CMP  = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        kwm_pkg::KIND_INSERT: begin
                            if (i_status.full) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = 1'b1;
                            end else begin
                                o_cmd.start_ins = 1'b1;
                                n_state         = S_UP_CHK;
                            end
                        end
                        kwm_pkg::KIND_ADVANCE: begin
                            if (i_status.zero) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = 1'b1;
                            end else begin
                                o_cmd.start_adv = 1'b1;
                                n_state         = S_DN_RD;
                            end
                        end
                        kwm_pkg::KIND_RETIRE: begin
                            if (i_status.zero) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.err  = 1'b1;
                            end else begin
                                o_cmd.start_ret = 1'b1;
                                n_state = i_status.one ? S_DONE : S_DN_LAST;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.err  = 1'b1;
                        end
                    endcase
                end
            end
            S_UP_CHK: begin
                if (i_status.idx_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status.up_less) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DN_LAST: begin
                o_cmd.take_last = 1'b1;
                n_state         = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_status.leaf) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd_dn = 1'b1;
                    n_state     = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_status.dn_swap) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !o_cmd.err) |=> busy)
        else $error("accepted operation did not occupy the controller");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> !busy)
        else $error("controller did not return to idle after a result");

endmodule

/* rtl/core/kway_merge_min_heap_top.sv */
// Top level of the k-way merge heap: binary min-heap of list heads with sift engine.
// Sequence: an error word is refused in idle and its result appears in the cycle after start;
// otherwise the word walks its sift states and then S_DONE (insert sifts up, advance and retire
// sift down, retire with more than one entry first fetches the last entry in S_DN_LAST).
// Throughput: one word at a time; busy stays high through the cycle that registers the
// result, and a new start is taken in the same cycle that the previous result strobes out.
// Each heap level moved takes a registered read (S_UP_CHK or S_DN_RD), then a compare-and-write.
// Reset (synchronous, active low) empties the heap; the receiver cannot stall a result.
module kway_merge_min_heap_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  kwm_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output kwm_pkg::t_out_item o_result
);

    // The controller decides which step comes next from the datapath status;
    // the datapath owns the entry memory, the hole entry being moved, the
    // current slot index, the entry count and a shadow copy of the root.
    kwm_pkg::t_cmd    cmd;
    kwm_pkg::t_status status;

    kwm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // The input word is sampled by the datapath only in the accept cycle.
    kwm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

/* tb/sv/kwm_heap_monitor.sv */
// Monitor for the k-way merge heap: predicts each result word and compares it with the block.
module kwm_heap_monitor #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  kwm_pkg::t_in_item  i_item,
    input  logic               i_valid,
    input  kwm_pkg::t_out_item i_result,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    import kwm_pkg::*;

    t_entry    heap_slot [SLOTS];
    int        held;
    t_out_item tops_due [$];

    // Smaller value wins; equal values go to the lower list number.
    function automatic logic sits_above(input t_entry a, input t_entry b);
        if (a.value == b.value) begin
            return a.list < b.list;
        end
        return a.value < b.value;
    endfunction

    task automatic swap_slots(input int a, input int b);
        t_entry t;
        t = heap_slot[a];
        heap_slot[a] = heap_slot[b];
        heap_slot[b] = t;
    endtask

    task automatic rise_from(input int start_slot);
        int i;
        int up;
        i = start_slot;
        while (i > 0) begin
            up = (i - 1) / 2;
            if (!sits_above(heap_slot[i], heap_slot[up])) begin
                break;
            end
            swap_slots(i, up);
            i = up;
        end
    endtask

    task automatic sink_from_root();
        int i;
        int l;
        int r;
        int m;
        i = 0;
        forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            m = i;
            if (l < held && sits_above(heap_slot[l], heap_slot[m])) begin
                m = l;
            end
            if (r < held && sits_above(heap_slot[r], heap_slot[m])) begin
                m = r;
            end
            if (m == i) begin
                break;
            end
            swap_slots(i, m);
            i = m;
        end
    endtask

    task automatic predict_word(input t_in_item w, output t_out_item res);
        logic refused;
        refused = 1'b0;
        case (w.kind)
            KIND_INSERT: begin
                if (held >= SLOTS) begin
                    refused = 1'b1;
                end else begin
                    heap_slot[held].value = w.value;
                    heap_slot[held].list  = w.list_id;
                    held++;
                    rise_from(held - 1);
                end
            end
            KIND_ADVANCE: begin
                if (held == 0) begin
                    refused = 1'b1;
                end else begin
                    heap_slot[0].value = w.value;
                    sink_from_root();
                end
            end
            KIND_RETIRE: begin
                if (held == 0) begin
                    refused = 1'b1;
                end else begin
                    held--;
                    heap_slot[0] = heap_slot[held];
                    sink_from_root();
                end
            end
            default: begin
                refused = 1'b1;
            end
        endcase
        res = '0;
        if (held != 0) begin
            res.top_value = heap_slot[0].value;
            res.top_list  = heap_slot[0].list;
        end
        res.count     = COUNT_W'(held);
        res.empty_res = (held == 0);
        res.error     = refused;
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            held = 0;
            tops_due.delete();
        end else begin
            // The result leaving now belongs to an older word, so it is matched first.
            if (i_valid === 1'b1) begin
                if (tops_due.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result word with nothing expected, expected none, got %p",
                             $time, i_result);
                end else begin
                    due = tops_due.pop_front();
                    check_field("top_value", due.top_value, i_result.top_value);
                    check_field("top_list", due.top_list, i_result.top_list);
                    check_field("count", due.count, i_result.count);
                    check_field("empty_res", due.empty_res, i_result.empty_res);
                    check_field("error", due.error, i_result.error);
                end
            end
            if (i_start && !i_busy) begin
                predict_word(i_item, due);
                tops_due.push_back(due);
            end
        end
        o_outstanding = tops_due.size();
    end

endmodule

/* tb/sv/tb_kway_merge_min_heap_top.sv */
// Testbench top for the k-way merge heap: stimulus, idling, watchdog and final verdict.
module tb_kway_merge_min_heap_top;
    import kwm_pkg::*;

    // Kind code the block does not define; it must be refused like any other error.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int SLOTS        = 16;
    localparam int RANDOM_WORDS = 500;
    // Cycles in a row with no word accepted on either side before the run is declared hung.
    // It is set well above the slowest word and the usual sender gaps.
    localparam int STALL_LIMIT  = 2000;
    // Settling time after the last result, a bit above the deepest sift latency.
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    int mismatches;
    int outstanding;
    int idle_pct;
    int words_sent;
    int quiet_cycles;
    int fill;
    bit growing;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    kway_merge_min_heap_top #(
        .CAPACITY (SLOTS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    kwm_heap_monitor #(
        .SLOTS (SLOTS)
    ) u_heap_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_kway_merge_min_heap_top failed");
                $finish;
            end
        end
    end

    function automatic t_in_item make_word(input logic [1:0] kind,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic [LIST_W-1:0] list_id);
        t_in_item w;
        w.kind    = kind;
        w.value   = value;
        w.list_id = list_id;
        return w;
    endfunction

    // Half the values come from a narrow band so that ties between lists are common;
    // the rest are full-width or picked from the signed extremes, zero and minus one.
    function automatic logic signed [VALUE_W-1:0] draw_value();
        int s;
        case ($urandom_range(0, 3))
            0, 1: begin
                s = $urandom_range(0, 16);
                return s - 8;
            end
            2: begin
                return $urandom;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // Presents one word from a falling edge and holds it until the block takes it.
    // The sender's idle rate follows the progress of the run: light idling first,
    // heavy idling next, and none at all at the end.
    task automatic send_word(input t_in_item w);
        if (words_sent < 175) begin
            idle_pct = 26;
        end else if (words_sent < 350) begin
            idle_pct = 80;
        end else begin
            idle_pct = 0;
        end
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = w;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        words_sent++;
    endtask

    initial begin
        t_in_item w;
        int roll;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. An empty heap refuses advance, retire and the spare kind code.
        send_word(make_word(KIND_RETIRE, 32'sd0, 4'd0));
        send_word(make_word(KIND_ADVANCE, 32'sh7fff_ffff, 4'hf));
        send_word(make_word(KIND_SPARE, -32'sd1, 4'hf));

        // Fill the heap to capacity with the value extremes and ties on equal values,
        // so that list order decides between them.
        send_word(make_word(KIND_INSERT, 32'sh7fff_ffff, 4'hf));
        send_word(make_word(KIND_INSERT, 32'sh8000_0000, 4'h0));
        send_word(make_word(KIND_INSERT, 32'sd0, 4'h7));
        send_word(make_word(KIND_INSERT, -32'sd1, 4'h3));
        send_word(make_word(KIND_INSERT, 32'sd5, 4'h9));
        send_word(make_word(KIND_INSERT, 32'sd5, 4'h2));
        send_word(make_word(KIND_INSERT, 32'sd5, 4'hc));
        send_word(make_word(KIND_INSERT, 32'sh8000_0000, 4'h1));
        send_word(make_word(KIND_INSERT, 32'sh7fff_ffff, 4'he));
        for (int k = 0; k < 7; k++) begin
            send_word(make_word(KIND_INSERT, k - 3, LIST_W'(k + 4)));
        end

        // A full heap refuses a further insert.
        send_word(make_word(KIND_INSERT, -32'sd7, 4'h5));

        // Advance the top to the largest value so it sinks all the way down,
        // then try the spare code on a non-empty heap and retire twice.
        send_word(make_word(KIND_ADVANCE, 32'sh7fff_ffff, 4'h0));
        send_word(make_word(KIND_SPARE, 32'sd0, 4'h0));
        send_word(make_word(KIND_RETIRE, 32'sd0, 4'ha));
        send_word(make_word(KIND_RETIRE, -32'sd1, 4'h5));
        fill    = SLOTS - 2;
        growing = 1'b0;

        // Random part: merge-like runs that grow the heap with inserts and drain it with
        // advances and retires, so it passes through every size between empty and full.
        // A small share of words is noise with any kind code, refusals among them.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            w = make_word(KIND_INSERT, draw_value(), LIST_W'($urandom_range(0, 15)));
            if (roll < 6) begin
                w.kind = 2'($urandom_range(0, 3));
            end else if (growing) begin
                if (fill > 0 && roll >= 78) begin
                    w.kind = KIND_ADVANCE;
                end
            end else begin
                w.kind = (roll < 55) ? KIND_ADVANCE : KIND_RETIRE;
            end
            send_word(w);

            if (w.kind == KIND_INSERT && fill < SLOTS) begin
                fill++;
            end else if (w.kind == KIND_RETIRE && fill > 0) begin
                fill--;
            end
            if (fill == SLOTS || (growing && fill > 0 && $urandom_range(0, 99) < 4)) begin
                growing = 1'b0;
            end else if (fill == 0 || (!growing && $urandom_range(0, 99) < 4)) begin
                growing = 1'b1;
            end
        end

        // All words are in; wait for the last results and let the block settle.
        start = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_kway_merge_min_heap_top passed");
        end else begin
            $display("tb_kway_merge_min_heap_top failed");
        end
        $finish;
    end

endmodule
